### hdl/isrt_pkg.sv
// Package for the idle slot reservation timeline: default sizes, codes and
// the per-cell operation type shared by the top level and the cell row.
// No dependencies.
package isrt_pkg;

    localparam int MAX_BOUNDARIES_DEF = 64;
    localparam int TIME_BITS_DEF      = 32;

    localparam logic       ACT_RESERVE = 1'b0;
    localparam logic       ACT_CLEAR   = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOFIT = 2'd2;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLEAR0,
        OP_INVAL,
        OP_TAKE_R,
        OP_TAKE_L,
        OP_SET_PRE,
        OP_SET_POST,
        OP_SPLIT_NEW
    } t_cell_op;

endpackage

### hdl/isrt_cell.sv
// One gap cell of the timeline row: holds one idle gap (start, end, valid),
// tests it against the pending request and shifts with its neighbors.
// Depends on isrt_pkg.
module isrt_cell #(
    parameter int TIME_BITS = isrt_pkg::TIME_BITS_DEF,
    parameter bit FIRST     = 1'b0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  isrt_pkg::t_cell_op      i_op,
    input  logic [TIME_BITS-1:0]    i_exec,
    input  logic [TIME_BITS-1:0]    i_ready,
    input  logic [TIME_BITS-1:0]    i_s,
    input  logic [TIME_BITS-1:0]    i_e,
    input  logic [TIME_BITS-1:0]    i_left_pre,
    input  logic [TIME_BITS-1:0]    i_left_post,
    input  logic                    i_left_valid,
    input  logic [TIME_BITS-1:0]    i_right_pre,
    input  logic [TIME_BITS-1:0]    i_right_post,
    input  logic                    i_right_valid,
    output logic [TIME_BITS-1:0]    o_pre,
    output logic [TIME_BITS-1:0]    o_post,
    output logic                    o_valid,
    output logic                    o_fit
);
    import isrt_pkg::*;

    logic [TIME_BITS-1:0] r_pre, n_pre;
    logic [TIME_BITS-1:0] r_post, n_post;
    logic                 r_valid, n_valid;
    logic                 r_fit, n_fit;
    logic [TIME_BITS-1:0] len;
    logic [TIME_BITS-1:0] latest;

    // latest start is only meaningful once the length test passes
    always_comb begin
        len    = r_post - r_pre;
        latest = r_post - i_exec;
        n_fit  = r_valid && (r_post >= r_pre) && (len >= i_exec) && (latest >= i_ready);
    end

    always_comb begin
        n_pre   = r_pre;
        n_post  = r_post;
        n_valid = r_valid;
        unique case (i_op)
            OP_HOLD: begin
            end
            OP_CLEAR0: begin
                n_pre   = '0;
                n_post  = '1;
                n_valid = 1'b1;
            end
            OP_INVAL: begin
                n_valid = 1'b0;
            end
            OP_TAKE_R: begin
                n_pre   = i_right_pre;
                n_post  = i_right_post;
                n_valid = i_right_valid;
            end
            OP_TAKE_L: begin
                n_pre   = i_left_pre;
                n_post  = i_left_post;
                n_valid = i_left_valid;
            end
            OP_SET_PRE: begin
                n_pre = i_e;
            end
            OP_SET_POST: begin
                n_post = i_s;
            end
            OP_SPLIT_NEW: begin
                n_pre   = i_e;
                n_post  = i_left_post;
                n_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n && FIRST) begin
            r_pre  <= '0;
            r_post <= '1;
        end else begin
            r_pre  <= n_pre;
            r_post <= n_post;
        end
        if (!i_rst_n) begin
            r_valid <= FIRST;
            r_fit   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_fit   <= n_fit;
        end
    end

    assign o_pre   = r_pre;
    assign o_post  = r_post;
    assign o_valid = r_valid;
    assign o_fit   = r_fit;

endmodule

### hdl/idle_slot_reservation_timeline_unit.sv
// o_done rises after an accepted transaction (start & !busy) passes the states
// evaluate (cells register their fit), select (lowest fitting cell isolated
// by one carry add) and apply (row shifts); the unit then returns to idle,
// where the result is shown and busy is low. A new transaction is accepted only in idle.
// Reset (synchronous, active low): timeline holds one gap from 0 to maximum time.
// The receiver cannot stall: o_done is a one-cycle strobe; results hold.
module idle_slot_reservation_timeline_unit #(
    parameter int MAX_BOUNDARIES = isrt_pkg::MAX_BOUNDARIES_DEF,
    parameter int TIME_BITS      = isrt_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [31:0] i_exec_time,
    input  logic [31:0] i_ready_time,
    output logic        o_done,
    output logic [31:0] o_start_time,
    output logic [31:0] o_end_time,
    output logic [1:0]  o_status
);
    import isrt_pkg::*;

    localparam int NC = MAX_BOUNDARIES / 2;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVAL  = 4'b0010,
        S_SEL   = 4'b0100,
        S_APPLY = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic                 r_action;
    logic [TIME_BITS-1:0] r_exec, r_ready;
    logic [NC-1:0]        r_win, r_ge;
    logic                 r_found;
    logic [TIME_BITS-1:0] r_sel_pre, r_sel_post;
    logic                 r_done;
    logic [31:0]          r_start, r_end;
    logic [1:0]           r_status;

    logic [TIME_BITS-1:0] cell_pre  [NC];
    logic [TIME_BITS-1:0] cell_post [NC];
    logic [NC-1:0]        cell_valid;
    logic [NC-1:0]        cell_fit;
    t_cell_op             cell_op   [NC];

    logic [NC-1:0]        neg_fit, win, ge, win_prev;
    logic [TIME_BITS-1:0] sel_pre, sel_post;
    logic [TIME_BITS-1:0] s, e;
    logic                 whole, cut_lo, cut_hi, full, active;
    logic [1:0]           status;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_EVAL;
            S_EVAL:  n_state = S_SEL;
            S_SEL:   n_state = S_APPLY;
            S_APPLY: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // lowest set fit bit and everything at or above it, from one negate
    always_comb begin
        neg_fit  = ~cell_fit + NC'(1);
        win      = cell_fit & neg_fit;
        ge       = cell_fit | neg_fit;
        sel_pre  = '0;
        sel_post = '0;
        for (int k = 0; k < NC; k++) begin
            sel_pre  = sel_pre  | (cell_pre[k]  & {TIME_BITS{win[k]}});
            sel_post = sel_post | (cell_post[k] & {TIME_BITS{win[k]}});
        end
    end

    always_comb begin
        s      = (r_sel_pre > r_ready) ? r_sel_pre : r_ready;
        e      = s + r_exec;
        cut_lo = (s == r_sel_pre);
        cut_hi = (e == r_sel_post);
        whole  = cut_lo && cut_hi;
        full   = cell_valid[NC-1];
        active = (r_state == S_APPLY) && (r_action == ACT_RESERVE) && r_found
                 && (r_exec != '0);
        if (r_action == ACT_CLEAR) begin
            status = ST_OK;
        end else if (!r_found) begin
            status = ST_NOFIT;
        end else if ((r_exec != '0) && !cut_lo && !cut_hi && full) begin
            status = ST_FULL;
        end else begin
            status = ST_OK;
        end
    end

    assign win_prev = {r_win[NC-2:0], 1'b0};

    always_comb begin
        for (int k = 0; k < NC; k++) begin
            cell_op[k] = OP_HOLD;
            if ((r_state == S_APPLY) && (r_action == ACT_CLEAR)) begin
                cell_op[k] = (k == 0) ? OP_CLEAR0 : OP_INVAL;
            end else if (active) begin
                if (whole) begin
                    if (r_ge[k]) cell_op[k] = OP_TAKE_R;
                end else if (cut_lo) begin
                    if (r_win[k]) cell_op[k] = OP_SET_PRE;
                end else if (cut_hi) begin
                    if (r_win[k]) cell_op[k] = OP_SET_POST;
                end else if (!full) begin
                    if (r_win[k])           cell_op[k] = OP_SET_POST;
                    else if (win_prev[k])   cell_op[k] = OP_SPLIT_NEW;
                    else if (r_ge[k])       cell_op[k] = OP_TAKE_L;
                end
            end
        end
    end

    for (genvar g = 0; g < NC; g++) begin : g_cell
        logic [TIME_BITS-1:0] l_pre, l_post, r_pre_n, r_post_n;
        logic                 l_valid, r_valid_n;
        if (g == 0) begin : g_left_edge
            assign l_pre   = '0;
            assign l_post  = '0;
            assign l_valid = 1'b0;
        end else begin : g_left
            assign l_pre   = cell_pre[g-1];
            assign l_post  = cell_post[g-1];
            assign l_valid = cell_valid[g-1];
        end
        if (g == NC-1) begin : g_right_edge
            assign r_pre_n   = '0;
            assign r_post_n  = '0;
            assign r_valid_n = 1'b0;
        end else begin : g_right
            assign r_pre_n   = cell_pre[g+1];
            assign r_post_n  = cell_post[g+1];
            assign r_valid_n = cell_valid[g+1];
        end
        isrt_cell #(
            .TIME_BITS (TIME_BITS),
            .FIRST     (g == 0)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_op          (cell_op[g]),
            .i_exec        (r_exec),
            .i_ready       (r_ready),
            .i_s           (s),
            .i_e           (e),
            .i_left_pre    (l_pre),
            .i_left_post   (l_post),
            .i_left_valid  (l_valid),
            .i_right_pre   (r_pre_n),
            .i_right_post  (r_post_n),
            .i_right_valid (r_valid_n),
            .o_pre         (cell_pre[g]),
            .o_post        (cell_post[g]),
            .o_valid       (cell_valid[g]),
            .o_fit         (cell_fit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_action <= i_action;
            r_exec   <= TIME_BITS'(i_exec_time);
            r_ready  <= TIME_BITS'(i_ready_time);
        end
        if (r_state == S_SEL) begin
            r_win      <= win;
            r_ge       <= ge;
            r_found    <= |cell_fit;
            r_sel_pre  <= sel_pre;
            r_sel_post <= sel_post;
        end
        if (r_state == S_APPLY) begin
            r_status <= status;
            if ((r_action == ACT_RESERVE) && (status == ST_OK)) begin
                r_start <= 32'(s);
                r_end   <= 32'(e);
            end else begin
                r_start <= '0;
                r_end   <= '0;
            end
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_APPLY);
        end
    end

    assign o_done       = r_done;
    assign o_start_time = r_start;
    assign o_end_time   = r_end;
    assign o_status     = r_status;

`ifndef SYNTH
    // gaps stay packed toward cell 0
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cell_valid & (cell_valid + NC'(1))) == '0)
        else $error("timeline cells not packed");

    a_win_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> $onehot0(r_win) && (r_found == (r_win != '0)))
        else $error("winner select not one-hot");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FULL)) |-> cell_valid[NC-1])
        else $error("full status with free cells");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_APPLY) && (r_action == ACT_CLEAR)) |=>
            o_done && cell_valid[0] && (o_status == ST_OK) && (o_start_time == '0))
        else $error("clear did not restore timeline");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$past(o_done) && !busy)
        else $error("result strobe longer than one cycle");
`endif

endmodule
